FILE: hdl/tcpct_pkg.sv
// Shared types and constants for the TCP handshake connection tracker.
package tcpct_pkg;

	// Table geometry defaults
	localparam int unsigned TABLE_ENTRIES_DEF = 1024;
	localparam int unsigned TABLE_WAYS_DEF    = 4;

	// Stream widths
	localparam int unsigned S_TDATA_W = 120;
	localparam int unsigned M_TDATA_W = 8;

	// Shortest frame that carries full Ethernet, IPv4 and TCP headers
	localparam logic [15:0] MIN_FRAME = 16'd54;

	// Connection phases
	localparam logic [1:0] PH_SYNSENT  = 2'd1;
	localparam logic [1:0] PH_SYNACKED = 2'd2;
	localparam logic [1:0] PH_ESTAB    = 2'd3;

	// Set-index mixing constant
	localparam logic [31:0] HASH_MULT = 32'h045d9f3b;

	// One way of a table row
	typedef struct packed {
		logic        valid;
		logic [63:0] key_addrs;
		logic [31:0] key_ports;
		logic [1:0]  phase;
		logic [31:0] server;
	} entry_t;

	// Outcome of one lookup
	typedef struct packed {
		logic allow;
		logic dropped;
	} verdict_t;

endpackage

FILE: hdl/tcpct_ram.sv
// Generic single-port synchronous RAM with registered read data.
module tcpct_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read one row
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: hdl/tcpct_hash.sv
// Set index: key fold, registered multiply, fold, mask or reciprocal remainder.
module tcpct_hash
	import tcpct_pkg::*;
#(
	parameter int unsigned SETS = 256,
	parameter int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      key_addrs,
	input  logic [31:0]      key_ports,
	output logic             done,
	output logic [SET_W-1:0] set_idx
);

	localparam int unsigned      REM_W  = SET_W + 1;
	localparam bit               POW2   = (SETS & (SETS - 1)) == 0;
	localparam logic [31:0]      RECIP  = (SETS > 1) ? 32'(64'h1_0000_0000 / 64'(SETS)) : 32'd0;
	localparam logic [31:0]      SETS_V = 32'(SETS);
	localparam logic [REM_W-1:0] SETS_R = REM_W'(SETS);

	localparam logic [2:0] H_IDLE = 3'd0;
	localparam logic [2:0] H_MUL  = 3'd1;
	localparam logic [2:0] H_FOLD = 3'd2;
	localparam logic [2:0] H_QUOT = 3'd3;
	localparam logic [2:0] H_BACK = 3'd4;
	localparam logic [2:0] H_SUB  = 3'd5;

	logic [2:0]       hstate_q;
	logic [31:0]      h1_q;
	logic [31:0]      prod_q;
	logic [31:0]      div_q;
	logic [31:0]      quot_q;
	logic [31:0]      back_q;
	logic             done_q;
	logic [SET_W-1:0] set_q;

	logic [31:0]      x_in;
	logic [31:0]      h2;
	logic [63:0]      qprod;
	logic [31:0]      diff;
	logic [REM_W-1:0] rem_raw;
	logic [REM_W-1:0] rem_fix;

	// Fold the key, and the product, into 32 bits
	assign x_in = key_addrs[63:32] ^ key_addrs[31:0] ^ key_ports;
	assign h2   = prod_q ^ (prod_q >> 16);

	// Estimate the quotient low by at most one, then correct the remainder once
	assign qprod   = 64'(div_q) * 64'(RECIP);
	assign diff    = div_q - back_q;
	assign rem_raw = diff[REM_W-1:0];
	assign rem_fix = (rem_raw >= SETS_R) ? rem_raw - SETS_R : rem_raw;

	// Sequence the hash steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstate_q <= H_IDLE;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (hstate_q)
				H_IDLE: begin
					if (start) begin
						hstate_q <= H_MUL;
					end
				end
				H_MUL: begin
					hstate_q <= H_FOLD;
				end
				H_FOLD: begin
					if (POW2) begin
						done_q   <= 1'b1;
						hstate_q <= H_IDLE;
					end else begin
						hstate_q <= H_QUOT;
					end
				end
				H_QUOT: begin
					hstate_q <= H_BACK;
				end
				H_BACK: begin
					hstate_q <= H_SUB;
				end
				H_SUB: begin
					done_q   <= 1'b1;
					hstate_q <= H_IDLE;
				end
				default: begin
					hstate_q <= H_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (hstate_q)
			H_IDLE: begin
				h1_q <= x_in ^ (x_in >> 16);
			end
			H_MUL: begin
				prod_q <= 32'(h1_q * HASH_MULT);
			end
			H_FOLD: begin
				div_q <= h2;
				set_q <= (SETS == 1) ? '0 : h2[SET_W-1:0];
			end
			H_QUOT: begin
				quot_q <= qprod[63:32];
			end
			H_BACK: begin
				back_q <= 32'(quot_q * SETS_V);
			end
			H_SUB: begin
				set_q <= rem_fix[SET_W-1:0];
			end
			default: begin
				h1_q <= h1_q;
			end
		endcase
	end

	assign done    = done_q;
	assign set_idx = set_q;

	// A result appears only after a fold or the remainder correction
	a_done_after_fold: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(hstate_q) == H_FOLD || $past(hstate_q) == H_SUB))
		else $error("set index done without a fold or remainder step");

endmodule

FILE: hdl/tcpct_update.sv
// Way match and row update for one connection table set.
module tcpct_update
	import tcpct_pkg::*;
#(
	parameter int unsigned WAYS = 4
) (
	input  entry_t [WAYS-1:0] row_in,
	input  logic [63:0]       key_addrs,
	input  logic [31:0]       key_ports,
	input  logic [31:0]       src_addr,
	input  logic [31:0]       dst_addr,
	input  logic              flag_syn,
	input  logic              flag_ack,
	input  logic              flag_fin,
	output entry_t [WAYS-1:0] row_out,
	output verdict_t          verdict
);

	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic             hit;
	logic             free;
	logic [WAY_W-1:0] hit_sel;
	logic [WAY_W-1:0] free_sel;
	entry_t           ent;
	logic             from_server;

	// Find the first matching way and the first free way
	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_sel  = '0;
		free_sel = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (row_in[w].valid) begin
				if (!hit && row_in[w].key_addrs == key_addrs &&
				    row_in[w].key_ports == key_ports) begin
					hit     = 1'b1;
					hit_sel = WAY_W'(w);
				end
			end else if (!free) begin
				free     = 1'b1;
				free_sel = WAY_W'(w);
			end
		end
	end

	assign ent         = row_in[hit_sel];
	assign from_server = src_addr == ent.server;

	// Advance the handshake, insert or free
	always_comb begin
		row_out         = row_in;
		verdict.allow   = 1'b0;
		verdict.dropped = 1'b0;
		if (!hit) begin
			if (flag_syn && !flag_ack) begin
				if (free) begin
					row_out[free_sel].valid     = 1'b1;
					row_out[free_sel].key_addrs = key_addrs;
					row_out[free_sel].key_ports = key_ports;
					row_out[free_sel].phase     = PH_SYNSENT;
					row_out[free_sel].server    = dst_addr;
				end else begin
					verdict.dropped = 1'b1;
				end
			end
		end else if (ent.phase == PH_ESTAB) begin
			if (flag_fin && flag_ack) begin
				row_out[hit_sel].valid = 1'b0;
			end
			verdict.allow = 1'b1;
		end else if (from_server) begin
			if (ent.phase == PH_SYNSENT && flag_syn && flag_ack) begin
				row_out[hit_sel].phase = PH_SYNACKED;
			end
		end else if (ent.phase == PH_SYNACKED && !flag_syn && flag_ack) begin
			row_out[hit_sel].phase = PH_ESTAB;
			verdict.allow          = 1'b1;
		end
	end

endmodule

FILE: hdl/tcp_handshake_connection_tracker_top.sv
// Top level: connection table sequencer with hash unit and update logic.
//
// Channel  Dir  Signals                     Transfer carries
// s_       in   s_tvalid s_tready s_tdata   one TCP/IPv4 header
// m_       out  m_tvalid m_tready m_tdata   one verdict per header
//
// A header passes through the key, hash, lookup and output states before the
// next header transfer is taken; when the set count is not a power of two the
// set index needs a reciprocal multiply, a back multiply and a correction step.
// A truncated frame goes from the key state straight to the output state.
// The table is one row per set in a single-port RAM; a full-length header
// reads its row once and writes it back once. After reset a clearing pass
// writes one row per cycle over all TABLE_ENTRIES/TABLE_WAYS rows (256 by
// default), with s_tready low. A stalled result holds in the output register
// while the next header is taken.
module tcp_handshake_connection_tracker_top
	import tcpct_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int unsigned TABLE_WAYS    = TABLE_WAYS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// frame_length[15:0], src_addr[47:16], dst_addr[79:48], src_port[95:80],
	// dst_port[111:96], flag_syn[112], flag_ack[113], flag_fin[114], zeros
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// allow[0], insert_dropped[1], zeros
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int unsigned SETS_RAW = TABLE_ENTRIES / TABLE_WAYS;
	localparam int unsigned SETS     = (SETS_RAW > 0) ? SETS_RAW : 1;
	localparam int unsigned SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned ROW_W    = TABLE_WAYS * $bits(entry_t);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_KEY   = 3'd2;
	localparam logic [2:0] ST_HASH  = 3'd3;
	localparam logic [2:0] ST_LOOK  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]       state_q;
	logic [SET_W-1:0] clr_q;
	logic [SET_W-1:0] set_q;

	// Header fields of the item at work
	logic [15:0] frame_length_q;
	logic [31:0] src_addr_q;
	logic [31:0] dst_addr_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;
	logic        flag_syn_q;
	logic        flag_ack_q;
	logic        flag_fin_q;
	logic [63:0] key_addrs_q;
	logic [31:0] key_ports_q;
	verdict_t    verdict_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [31:0]       alo;
	logic [31:0]       ahi;
	logic [15:0]       plo;
	logic [15:0]       phi;
	logic [63:0]       key_addrs;
	logic [31:0]       key_ports;
	logic              hash_start;
	logic              hash_done;
	logic [SET_W-1:0]  hash_set;
	logic              ram_en;
	logic              ram_we;
	logic [SET_W-1:0]  ram_addr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  ram_rdata;
	entry_t [TABLE_WAYS-1:0] row_rd;
	entry_t [TABLE_WAYS-1:0] row_wr;
	verdict_t          verdict;
	logic              out_free;

	// Order the key so both directions share one entry
	assign alo       = (src_addr_q < dst_addr_q) ? src_addr_q : dst_addr_q;
	assign ahi       = (src_addr_q < dst_addr_q) ? dst_addr_q : src_addr_q;
	assign plo       = (src_port_q < dst_port_q) ? src_port_q : dst_port_q;
	assign phi       = (src_port_q < dst_port_q) ? dst_port_q : src_port_q;
	assign key_addrs = {alo, ahi};
	assign key_ports = {plo, phi};

	assign hash_start = (state_q == ST_KEY) && (frame_length_q >= MIN_FRAME);

	tcpct_hash #(
		.SETS  (SETS),
		.SET_W (SET_W)
	) u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (hash_start),
		.key_addrs (key_addrs),
		.key_ports (key_ports),
		.done      (hash_done),
		.set_idx   (hash_set)
	);

	// Clear rows after reset, read on hash done, write back on lookup
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = set_q;
		ram_wdata = row_wr;
		case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_HASH: begin
				ram_en   = hash_done;
				ram_addr = hash_set;
			end
			ST_LOOK: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	tcpct_ram #(
		.WIDTH  (ROW_W),
		.DEPTH  (SETS),
		.ADDR_W (SET_W)
	) u_table (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign row_rd = ram_rdata;

	tcpct_update #(
		.WAYS (TABLE_WAYS)
	) u_update (
		.row_in    (row_rd),
		.key_addrs (key_addrs_q),
		.key_ports (key_ports_q),
		.src_addr  (src_addr_q),
		.dst_addr  (dst_addr_q),
		.flag_syn  (flag_syn_q),
		.flag_ack  (flag_ack_q),
		.flag_fin  (flag_fin_q),
		.row_out   (row_wr),
		.verdict   (verdict)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// Sequence one header at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_KEY;
					end
				end
				ST_KEY: begin
					state_q <= (frame_length_q < MIN_FRAME) ? ST_OUT : ST_HASH;
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the header, key, set and verdict
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			frame_length_q <= s_tdata[15:0];
			src_addr_q     <= s_tdata[47:16];
			dst_addr_q     <= s_tdata[79:48];
			src_port_q     <= s_tdata[95:80];
			dst_port_q     <= s_tdata[111:96];
			flag_syn_q     <= s_tdata[112];
			flag_ack_q     <= s_tdata[113];
			flag_fin_q     <= s_tdata[114];
		end
		if (state_q == ST_KEY) begin
			key_addrs_q <= key_addrs;
			key_ports_q <= key_ports;
			verdict_q   <= '0;
		end
		if (state_q == ST_HASH && hash_done) begin
			set_q <= hash_set;
		end
		if (state_q == ST_LOOK) begin
			verdict_q <= verdict;
		end
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {{(M_TDATA_W - 2){1'b0}}, verdict_q.dropped, verdict_q.allow};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Table writes come only from the clearing pass or a lookup
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_LOOK))
		else $error("table write outside clear or lookup");

	// Lookup always follows the read issued on hash done
	a_look_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK |-> ($past(state_q) == ST_HASH && $past(hash_done)))
		else $error("lookup without a preceding row read");

	// The hash unit reports only while the sequencer waits for it
	a_hash_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == ST_HASH)
		else $error("set index arrived outside the wait state");

	// A new result is loaded only from the output state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result presented without passing the output state");

endmodule

FILE: test/tcp_handshake_connection_tracker_top_tb.sv
// Self-checking testbench for the TCP handshake connection tracker.
module tcp_handshake_connection_tracker_top_tb
	import tcpct_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TBL_ENTRIES = TABLE_ENTRIES_DEF;
	localparam int unsigned TBL_WAYS    = TABLE_WAYS_DEF;
	localparam int unsigned TBL_SETS    = (TBL_ENTRIES / TBL_WAYS) ? (TBL_ENTRIES / TBL_WAYS) : 1;
	localparam int unsigned RANDOM_ITEMS = 2000;
	localparam int unsigned POOL_SIZE    = 16;
	localparam int unsigned GROUP_SIZE   = 6;
	localparam int unsigned HOLD_AT      = 700;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned TAIL_CYCLES  = 60;

	typedef struct {
		bit [15:0] frame_length;
		bit [31:0] src_addr;
		bit [31:0] dst_addr;
		bit [15:0] src_port;
		bit [15:0] dst_port;
		bit        flag_syn;
		bit        flag_ack;
		bit        flag_fin;
	} hdr_t;

	typedef struct {
		hdr_t        hdr;
		int unsigned gap;
		bit          drain;
	} pending_t;

	typedef struct {
		bit [31:0] cli_addr;
		bit [31:0] srv_addr;
		bit [15:0] cli_port;
		bit [15:0] srv_port;
	} conn_t;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Tracker state as predicted from the accepted headers
	bit        conn_valid  [TBL_ENTRIES];
	bit [63:0] conn_addrs  [TBL_ENTRIES];
	bit [31:0] conn_ports  [TBL_ENTRIES];
	bit [1:0]  conn_phase  [TBL_ENTRIES];
	bit [31:0] conn_server [TBL_ENTRIES];

	pending_t    pending_items[$];
	verdict_t    verdicts_due[$];
	int unsigned handed_off;
	int unsigned headers_seen;
	int unsigned verdicts_checked;
	int unsigned verdicts_taken;
	int unsigned fault_count;
	int unsigned gap_left;
	int unsigned stall_left;
	bit          gap_quiet;
	bit          drain_next;

	tcp_handshake_connection_tracker_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Order the pair so both directions of a flow map to one key
	function automatic void flow_key(input bit [31:0] sa, input bit [31:0] da,
			input bit [15:0] sp, input bit [15:0] dp,
			output bit [63:0] ka, output bit [31:0] kp);
		ka = (sa < da) ? {sa, da} : {da, sa};
		kp = (sp < dp) ? {sp, dp} : {dp, sp};
	endfunction

	function automatic int unsigned set_index(bit [63:0] ka, bit [31:0] kp);
		bit [31:0] h;
		h = ka[63:32] ^ ka[31:0] ^ kp;
		h = h ^ (h >> 16);
		h = h * HASH_MULT;
		h = h ^ (h >> 16);
		return h % TBL_SETS;
	endfunction

	// Look up the flow, advance its handshake phase and produce the verdict
	function automatic verdict_t track_header(hdr_t h);
		verdict_t    v;
		bit [63:0]   ka;
		bit [31:0]   kp;
		int          hit;
		int          vacant;
		int unsigned base;
		int unsigned idx;
		bit          from_server;
		v = '0;
		if (h.frame_length < MIN_FRAME)
			return v;
		flow_key(h.src_addr, h.dst_addr, h.src_port, h.dst_port, ka, kp);
		base = set_index(ka, kp) * TBL_WAYS;
		hit = -1;
		vacant = -1;
		for (int w = 0; w < TBL_WAYS; w++) begin
			idx = base + w;
			if (idx >= TBL_ENTRIES)
				break;
			if (conn_valid[idx]) begin
				if (hit < 0 && conn_addrs[idx] == ka && conn_ports[idx] == kp)
					hit = idx;
			end else if (vacant < 0) begin
				vacant = idx;
			end
		end
		if (hit < 0) begin
			// Only a pure SYN opens a flow
			if (h.flag_syn && !h.flag_ack) begin
				if (vacant >= 0) begin
					conn_valid[vacant]  = 1'b1;
					conn_addrs[vacant]  = ka;
					conn_ports[vacant]  = kp;
					conn_phase[vacant]  = PH_SYNSENT;
					conn_server[vacant] = h.dst_addr;
				end else begin
					v.dropped = 1'b1;
				end
			end
		end else begin
			from_server = (h.src_addr == conn_server[hit]);
			if (conn_phase[hit] == PH_ESTAB) begin
				if (h.flag_fin && h.flag_ack)
					conn_valid[hit] = 1'b0;
				v.allow = 1'b1;
			end else if (from_server) begin
				if (conn_phase[hit] == PH_SYNSENT && h.flag_syn && h.flag_ack)
					conn_phase[hit] = PH_SYNACKED;
			end else if (conn_phase[hit] == PH_SYNACKED && !h.flag_syn && h.flag_ack) begin
				conn_phase[hit] = PH_ESTAB;
				v.allow = 1'b1;
			end
		end
		return v;
	endfunction

	function automatic conn_t random_conn();
		conn_t c;
		c.cli_addr = $urandom;
		c.srv_addr = $urandom;
		c.cli_port = 16'($urandom_range(0, 65535));
		c.srv_port = 16'($urandom_range(0, 65535));
		return c;
	endfunction

	// Search random flows until one lands in the wanted set
	function automatic conn_t conn_in_set(int unsigned target);
		conn_t     c;
		bit [63:0] ka;
		bit [31:0] kp;
		do begin
			c = random_conn();
			flow_key(c.cli_addr, c.srv_addr, c.cli_port, c.srv_port, ka, kp);
		end while (set_index(ka, kp) != target);
		return c;
	endfunction

	task automatic queue_hdr(bit [15:0] len, bit [31:0] sa, bit [31:0] da, bit [15:0] sp,
			bit [15:0] dp, bit syn, bit ack, bit fin);
		pending_t p;
		p.hdr.frame_length = len;
		p.hdr.src_addr     = sa;
		p.hdr.dst_addr     = da;
		p.hdr.src_port     = sp;
		p.hdr.dst_port     = dp;
		p.hdr.flag_syn     = syn;
		p.hdr.flag_ack     = ack;
		p.hdr.flag_fin     = fin;
		p.gap              = gap_quiet ? 0 : $urandom_range(0, 17);
		p.drain            = drain_next;
		drain_next         = 1'b0;
		pending_items.push_back(p);
	endtask

	task automatic queue_pkt(conn_t c, bit from_cli, bit syn, bit ack, bit fin);
		bit [15:0] len;
		len = ($urandom_range(0, 7) == 0) ? MIN_FRAME : 16'($urandom_range(54, 65535));
		if (from_cli)
			queue_hdr(len, c.cli_addr, c.srv_addr, c.cli_port, c.srv_port, syn, ack, fin);
		else
			queue_hdr(len, c.srv_addr, c.cli_addr, c.srv_port, c.cli_port, syn, ack, fin);
	endtask

	// Driver: offer pending headers with a drawn gap after each transfer
	always @(posedge clk or negedge arst_n) begin : tx_side
		pending_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_left <= 0;
			handed_off = 0;
		end else begin
			if (s_tvalid && s_tready)
				handed_off = handed_off + 1;
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					s_tvalid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_items.size() != 0 &&
						!(pending_items[0].drain && handed_off != verdicts_checked)) begin
					nxt = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {5'b0, nxt.hdr.flag_fin, nxt.hdr.flag_ack, nxt.hdr.flag_syn,
						nxt.hdr.dst_port, nxt.hdr.src_port, nxt.hdr.dst_addr,
						nxt.hdr.src_addr, nxt.hdr.frame_length};
					gap_left <= nxt.gap;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: often stall after a verdict, but not after verdicts 201 to 450; one long hold-off
	always @(posedge clk or negedge arst_n) begin : rx_side
		int unsigned pick;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			verdicts_taken <= 0;
		end else if (m_tvalid && m_tready) begin
			verdicts_taken <= verdicts_taken + 1;
			if (verdicts_taken + 1 == HOLD_AT) begin
				m_tready <= 1'b0;
				stall_left <= LONG_HOLD;
			end else if (verdicts_taken < 200 || verdicts_taken >= 450) begin
				pick = $urandom_range(0, 17);
				if (pick != 0) begin
					m_tready <= 1'b0;
					stall_left <= pick;
				end
			end
		end else if (!m_tready) begin
			if (stall_left > 1)
				stall_left <= stall_left - 1;
			else
				m_tready <= 1'b1;
		end
	end

	// Monitor: check each verdict, then predict for each accepted header
	always @(posedge clk) begin : watch
		verdict_t want;
		hdr_t     h;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					$error("verdict with none due: allow %0b insert_dropped %0b",
						m_tdata[0], m_tdata[1]);
					fault_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (m_tdata[0] !== want.allow) begin
						$error("allow: expected %0b, actual %0b", want.allow, m_tdata[0]);
						fault_count++;
					end
					if (m_tdata[1] !== want.dropped) begin
						$error("insert_dropped: expected %0b, actual %0b",
							want.dropped, m_tdata[1]);
						fault_count++;
					end
					verdicts_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				h.frame_length = s_tdata[15:0];
				h.src_addr     = s_tdata[47:16];
				h.dst_addr     = s_tdata[79:48];
				h.src_port     = s_tdata[95:80];
				h.dst_port     = s_tdata[111:96];
				h.flag_syn     = s_tdata[112];
				h.flag_ack     = s_tdata[113];
				h.flag_fin     = s_tdata[114];
				verdicts_due.push_back(track_header(h));
				headers_seen++;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		conn_t       a_conn;
		conn_t       b_conn;
		conn_t       grp [GROUP_SIZE];
		conn_t       pool [POOL_SIZE];
		int unsigned step [POOL_SIZE];
		int unsigned grp_set;
		int unsigned counted;
		int unsigned pick;
		int unsigned c;
		bit [2:0]    f;

		foreach (conn_valid[i])
			conn_valid[i] = 1'b0;
		handed_off = 0;
		headers_seen = 0;
		verdicts_checked = 0;
		fault_count = 0;
		gap_quiet = 1'b0;
		drain_next = 1'b0;

		// Extreme flow: lowest client against highest server
		a_conn.cli_addr = 32'h0;
		a_conn.srv_addr = 32'hFFFF_FFFF;
		a_conn.cli_port = 16'h0;
		a_conn.srv_port = 16'hFFFF;
		// Client and server share an address, so every packet looks server-sent
		b_conn = random_conn();
		b_conn.srv_addr = b_conn.cli_addr;
		grp_set = $urandom_range(0, TBL_SETS - 1);
		foreach (grp[i])
			grp[i] = conn_in_set(grp_set);

		// Truncated frames, one with every field but the length high
		queue_hdr(16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1);
		queue_hdr(MIN_FRAME - 16'd1, a_conn.cli_addr, a_conn.srv_addr, a_conn.cli_port,
			a_conn.srv_port, 1, 0, 0);
		// Misses that are not a pure SYN
		queue_pkt(a_conn, 0, 1, 1, 0);
		queue_pkt(a_conn, 1, 0, 1, 0);
		// Full handshake with the stray packets each phase ignores
		queue_hdr(MIN_FRAME, a_conn.cli_addr, a_conn.srv_addr, a_conn.cli_port,
			a_conn.srv_port, 1, 0, 0);
		queue_pkt(a_conn, 1, 1, 0, 0);
		queue_pkt(a_conn, 1, 1, 1, 0);
		queue_pkt(a_conn, 0, 0, 1, 0);
		queue_pkt(a_conn, 0, 1, 1, 0);
		queue_pkt(a_conn, 0, 1, 1, 0);
		queue_pkt(a_conn, 1, 1, 1, 0);
		queue_pkt(a_conn, 1, 0, 1, 0);
		queue_pkt(a_conn, 0, 0, 0, 1);
		queue_hdr(16'hFFFF, a_conn.srv_addr, a_conn.cli_addr, a_conn.srv_port,
			a_conn.cli_port, 0, 1, 0);
		queue_pkt(a_conn, 1, 0, 1, 1);
		queue_pkt(a_conn, 0, 0, 1, 0);
		// Shared address never reaches established
		queue_pkt(b_conn, 1, 1, 0, 0);
		queue_pkt(b_conn, 0, 1, 1, 0);
		queue_pkt(b_conn, 1, 0, 1, 0);
		// Overfill one set
		for (int i = 0; i < 5; i++)
			queue_pkt(grp[i], 1, 1, 0, 0);
		queue_pkt(grp[0], 0, 1, 1, 0);

		// Random part: the first pool slots all share one set
		drain_next = 1'b1;
		foreach (pool[i]) begin
			pool[i] = (i < GROUP_SIZE) ? grp[i] : random_conn();
			step[i] = (i < 1) ? 2 : (i < 4) ? 1 : 0;
		end
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			gap_quiet = (counted >= 600 && counted < 1000);
			if (counted == 1500)
				drain_next = 1'b1;
			pick = $urandom_range(0, 99);
			c = $urandom_range(0, POOL_SIZE - 1);
			if (pick < 60) begin
				// Next step of a well-formed connection
				case (step[c])
					0: begin
						queue_pkt(pool[c], 1, 1, 0, 0);
						step[c] = 1;
					end
					1: begin
						queue_pkt(pool[c], 0, 1, 1, 0);
						step[c] = 2;
					end
					2: begin
						queue_pkt(pool[c], 1, 0, 1, 0);
						step[c] = 3;
					end
					3: begin
						queue_pkt(pool[c], 1'($urandom_range(0, 1)), 0, 1, 0);
						if ($urandom_range(0, 2) == 0)
							step[c] = 4;
					end
					default: begin
						queue_pkt(pool[c], 1'($urandom_range(0, 1)), 0, 1, 1);
						step[c] = 0;
						if (c >= GROUP_SIZE && $urandom_range(0, 1))
							pool[c] = random_conn();
					end
				endcase
				counted++;
			end else if (pick < 80) begin
				f = 3'($urandom_range(0, 7));
				queue_pkt(pool[c], 1'($urandom_range(0, 1)), f[2], f[1], f[0]);
				counted++;
			end else if (pick < 90) begin
				f = 3'($urandom_range(0, 7));
				queue_hdr(16'($urandom_range(0, MIN_FRAME - 1)), pool[c].cli_addr,
					pool[c].srv_addr, pool[c].cli_port, pool[c].srv_port, f[2], f[1], f[0]);
				counted++;
			end else begin
				f = 3'($urandom_range(0, 7));
				queue_hdr(16'($urandom_range(0, 65535)), $urandom, $urandom,
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					f[2], f[1], f[0]);
				counted++;
			end
		end

		// Hold reset, then release at an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every header to be sent and every verdict checked
		@(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || verdicts_checked != headers_seen)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0 && verdicts_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/tcpct_pkg.sv
hdl/tcpct_ram.sv
hdl/tcpct_hash.sv
hdl/tcpct_update.sv
hdl/tcp_handshake_connection_tracker_top.sv
test/tcp_handshake_connection_tracker_top_tb.sv
